// File: design/ipot_pkg.sv
package ipot_pkg;

    // Request codes carried in req_type; codes above REQ_QUERY act as a query
    typedef enum logic [3:0] {
        REQ_TICK      = 4'd0,
        REQ_START     = 4'd1,
        REQ_STOP      = 4'd2,
        REQ_REFRESH   = 4'd3,
        REQ_INHIBIT   = 4'd4,
        REQ_CLR_INH   = 4'd5,
        REQ_CHARGER   = 4'd6,
        REQ_START_ABS = 4'd7,
        REQ_SHUTDOWN  = 4'd8,
        REQ_CANCEL    = 4'd9,
        REQ_QUERY     = 4'd10
    } req_code_t;

    // Reset value of the base timeout register
    localparam logic [31:0] BASE_TIMEOUT_RST = 32'd60000;

    // One input beat
    typedef struct packed {
        logic [3:0]  req_type;
        logic [31:0] value;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic        expired;
        logic        first_shutdown;
        logic        shutdown_latched;
        logic        running;
        logic [31:0] configured_timeout;
        logic [31:0] remaining_ms;
    } res_item_t;

endpackage

// File: design/ipot_in_stage.sv
module ipot_in_stage
    import ipot_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     fire,
    output logic     q_valid,
    output in_item_t q_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Take a new beat when empty or when the held one moves on this cycle
    assign in_ready = !valid_reg || fire;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// File: design/ipot_core.sv
module ipot_core
    import ipot_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        fire,
    input  in_item_t    item,
    output res_item_t   res
);

    localparam logic [TIME_WIDTH-1:0] TimeInf = {TIME_WIDTH{1'b1}};
    localparam logic [TIME_WIDTH-1:0] TimeLim = TimeInf - 1'b1;

    logic [TIME_WIDTH-1:0] base_reg;
    logic [TIME_WIDTH-1:0] cd_reg;
    logic [TIME_WIDTH-1:0] cd_next;
    logic [TIME_WIDTH-1:0] cd_cmd;
    logic                  armed_reg;
    logic                  armed_next;
    logic                  armed_cmd;
    logic                  run_reg;
    logic                  run_next;
    logic [TIME_WIDTH-1:0] inh_reg;
    logic [TIME_WIDTH-1:0] inh_next;
    logic [TIME_WIDTH-1:0] chg_reg;
    logic [TIME_WIDTH-1:0] chg_next;
    logic                  latch_reg;
    logic                  latch_next;
    logic                  arm_tmo;
    logic                  expired_c;
    logic                  first_c;
    logic [TIME_WIDTH-1:0] val_tw;
    logic [TIME_WIDTH+1:0] sum3;
    logic [TIME_WIDTH-1:0] tmo;

    assign val_tw = TIME_WIDTH'(item.value);

    // Command decode: state updates other than loading the computed timeout
    always_comb
    begin
        cd_cmd     = cd_reg;
        armed_cmd  = armed_reg;
        run_next   = run_reg;
        inh_next   = inh_reg;
        chg_next   = chg_reg;
        latch_next = latch_reg;
        arm_tmo    = 1'b0;
        expired_c  = 1'b0;
        first_c    = 1'b0;
        unique case (item.req_type)
            REQ_TICK:
            begin
                if (armed_reg && (cd_reg != TimeInf))
                begin
                    if (cd_reg <= TIME_WIDTH'(1))
                    begin
                        cd_cmd    = '0;
                        armed_cmd = 1'b0;
                        expired_c = 1'b1;
                    end
                    else
                    begin
                        cd_cmd = cd_reg - 1'b1;
                    end
                end
            end
            REQ_START:
            begin
                if (!latch_reg)
                begin
                    run_next = 1'b1;
                    arm_tmo  = 1'b1;
                end
            end
            REQ_STOP:
            begin
                run_next  = 1'b0;
                armed_cmd = 1'b0;
                cd_cmd    = '0;
                inh_next  = '0;
            end
            REQ_REFRESH:
            begin
                arm_tmo = run_reg && !latch_reg;
            end
            REQ_INHIBIT, REQ_CLR_INH, REQ_CHARGER:
            begin
                if (!latch_reg)
                begin
                    if (item.req_type == REQ_INHIBIT)
                    begin
                        inh_next = val_tw;
                    end
                    else if (item.req_type == REQ_CLR_INH)
                    begin
                        inh_next = '0;
                    end
                    else
                    begin
                        chg_next = val_tw;
                    end
                    arm_tmo = run_reg;
                end
            end
            REQ_START_ABS:
            begin
                if (!latch_reg)
                begin
                    run_next  = 1'b1;
                    inh_next  = '0;
                    cd_cmd    = val_tw;
                    armed_cmd = 1'b1;
                end
            end
            REQ_SHUTDOWN:
            begin
                first_c    = !latch_reg;
                latch_next = 1'b1;
                run_next   = 1'b0;
                armed_cmd  = 1'b0;
                cd_cmd     = '0;
            end
            REQ_CANCEL:
            begin
                latch_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Timeout from the updated extensions: one three-input add, then clamp; an infinite inhibit gives infinite
    always_comb
    begin
        sum3 = {2'b00, base_reg} + {2'b00, inh_next} + {2'b00, chg_next};
        if (inh_next == TimeInf)
        begin
            tmo = TimeInf;
        end
        else if (sum3 > {2'b00, TimeLim})
        begin
            tmo = TimeLim;
        end
        else
        begin
            tmo = sum3[TIME_WIDTH-1:0];
        end
    end

    // Re-arm with the fresh timeout where the command asks for it
    always_comb
    begin
        cd_next    = arm_tmo ? tmo : cd_cmd;
        armed_next = arm_tmo | armed_cmd;
    end

    // Result of the beat, taken by the output register on fire
    always_comb
    begin
        res.expired            = expired_c;
        res.first_shutdown     = first_c;
        res.shutdown_latched   = latch_next;
        res.running            = run_next;
        res.configured_timeout = 32'(tmo);
        res.remaining_ms       = armed_next ? 32'(cd_next) : 32'd0;
    end

    // Timer state and base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= TIME_WIDTH'(BASE_TIMEOUT_RST);
            cd_reg    <= '0;
            armed_reg <= 1'b0;
            run_reg   <= 1'b0;
            inh_reg   <= '0;
            chg_reg   <= '0;
            latch_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= TIME_WIDTH'(cfg_wdata);
            end
            if (fire)
            begin
                cd_reg    <= cd_next;
                armed_reg <= armed_next;
                run_reg   <= run_next;
                inh_reg   <= inh_next;
                chg_reg   <= chg_next;
                latch_reg <= latch_next;
            end
        end
    end

endmodule

// File: design/ipot_out_stage.sv
module ipot_out_stage
    import ipot_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  res_item_t res,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output res_item_t out_res
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t res_reg;

    // Room for a new result when empty or when the held one drains now
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: design/inactivity_power_off_timer_core.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_ready  | req_type, value
// result   | out_valid/out_ready  | expired, first_shutdown, shutdown_latched,
//          |                      | running, configured_timeout, remaining_ms
// config   | cfg_we               | cfg_wdata (base timeout, ms)
//
// One beat per cycle sustained while the result register is not stalled;
// a result passes through the input register, then the result register.
// The timer state updates in the cycle the beat leaves the input register;
// the timeout is one three-input add plus a clamp on that path.
// Reset clears the timer, extensions and shutdown latch; base is 60000 ms.
// A stalled result register holds the input register; input stays open
// while either register has room.
module inactivity_power_off_timer_core
    import ipot_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        expired,
    output logic        first_shutdown,
    output logic        shutdown_latched,
    output logic        running,
    output logic [31:0] configured_timeout,
    output logic [31:0] remaining_ms
);

    in_item_t  in_item;
    in_item_t  q_item;
    logic      q_valid;
    logic      space;
    logic      fire;
    res_item_t res;
    res_item_t out_res;

    assign in_item.req_type = req_type;
    assign in_item.value    = value;

    // Beat moves from input register to result register
    assign fire = q_valid && space;

    ipot_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .fire     (fire),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    ipot_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (q_item),
        .res       (res)
    );

    ipot_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign expired            = out_res.expired;
    assign first_shutdown     = out_res.first_shutdown;
    assign shutdown_latched   = out_res.shutdown_latched;
    assign running            = out_res.running;
    assign configured_timeout = out_res.configured_timeout;
    assign remaining_ms       = out_res.remaining_ms;

    // The shutdown latch and the running mark are never both set
    a_latch_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(shutdown_latched && running))
        else $error("running mark set while shutdown latched");

    // A first shutdown call leaves the latch set and the timer disarmed
    a_first_shutdown: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_shutdown) |-> (shutdown_latched && remaining_ms == 32'd0
                                           && !expired))
        else $error("first shutdown call with inconsistent state");

    // An expiring tick leaves nothing on the countdown
    a_expired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && expired) |-> (remaining_ms == 32'd0))
        else $error("expired with countdown left");

    // No beat enters the core while the result register is full and stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !fire)
        else $error("result register overrun");

endmodule
